FILE: sv/positional_list_engine_defines.svh
// assertion macros shared by the positional list engine checker
// no dependencies; include by bare file name
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// overlapping implication, disabled while reset is asserted
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("ple assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("ple assertion failed");

`endif

FILE: sv/ple_pkg.sv
// shared types and constants of the positional list engine
// no dependencies
`default_nettype none

package ple_pkg;

  localparam int unsigned DepthDefault = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

`default_nettype wire

FILE: sv/positional_list_engine.sv
// a command transfer passes the input register and then the result register before its done_o strobe
// throughput: one command per cycle; busy stays low, the row never stalls
// rate is set by the input register, the shifting cell row and the result register
// reset (async, active low) clears the entry count and the pipeline valids;
// cell contents are undefined until written and are never read before that
// top level of the positional list engine; depends on ple_pkg
`default_nettype none

module positional_list_engine #(
  parameter int unsigned DEPTH = ple_pkg::DepthDefault,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          command_i,
  input  wire logic [7:0]          position_i,
  input  wire logic signed [31:0]  value_in_i,
  output logic                     done_o,
  output logic signed [31:0]       value_out_o,
  output logic [1:0]               status_o,
  output logic [CntW-1:0]          entry_count_o
);
  import ple_pkg::*;

  // index width for the read mux and width for position/count compares
  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CmpW = ((CntW > 8) ? CntW : 8) + 1;

  // input register stage
  logic               in_vld_q;
  cmd_e               cmd_q;
  logic [7:0]         pos_q;
  logic signed [31:0] val_q;

  // list state: cell k-1 holds position k
  logic signed [31:0] cells_q [DEPTH];
  logic signed [31:0] cells_d [DEPTH];
  logic [CntW-1:0]    cnt_q;
  logic [CntW-1:0]    cnt_d;

  // result register stage
  logic               res_vld_q;
  logic signed [31:0] res_val_q;
  status_e            res_st_q;
  logic [CntW-1:0]    res_cnt_q;

  // per-command decode
  status_e            st;
  logic signed [31:0] rd_val;
  logic               do_ins;
  logic               do_rem;
  logic [CmpW-1:0]    pos_ext;
  logic [CmpW-1:0]    cnt_ext;
  logic [7:0]         pos_m1;
  logic [IdxW-1:0]    rd_idx;

  // every command is taken on the cycle it shows up
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_e'(command_i);
      pos_q <= position_i;
      val_q <= value_in_i;
    end
  end

  assign pos_ext = CmpW'(pos_q);
  assign cnt_ext = CmpW'(cnt_q);
  assign pos_m1  = pos_q - 8'd1;
  assign rd_idx  = pos_m1[IdxW-1:0];

  // range and full checks; insert checks range before full
  always_comb begin
    st     = ST_OK;
    rd_val = '0;
    cnt_d  = cnt_q;
    do_ins = 1'b0;
    do_rem = 1'b0;
    if (in_vld_q) begin
      case (cmd_q)
        CMD_INSERT: begin
          if ((pos_q == 8'd0) || (pos_ext > cnt_ext + CmpW'(1))) begin
            st = ST_RANGE;
          end else if (cnt_q == CntW'(DEPTH)) begin
            st = ST_FULL;
          end else begin
            do_ins = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end
        end
        CMD_READ: begin
          if ((pos_q == 8'd0) || (pos_ext > cnt_ext)) begin
            st = ST_RANGE;
          end else begin
            rd_val = cells_q[rd_idx];
          end
        end
        CMD_REMOVE: begin
          if ((pos_q == 8'd0) || (pos_ext > cnt_ext)) begin
            st = ST_RANGE;
          end else begin
            do_rem = 1'b1;
            cnt_d  = cnt_q - CntW'(1);
          end
        end
        CMD_CLEAR: begin
          cnt_d = '0;
        end
        default: begin
          st = ST_OK;
        end
      endcase
    end
  end

  // each cell picks its own value, its lower neighbor (insert shift up)
  // or its upper neighbor (remove shift down); cells past the count
  // may take stale data, they are never read before being written
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    localparam int unsigned Prev = (g > 0) ? g - 1 : 0;
    localparam int unsigned Next = (g < DEPTH - 1) ? g + 1 : g;
    localparam logic [CmpW-1:0] SlotPos = CmpW'(g + 1);

    always_comb begin
      cells_d[g] = cells_q[g];
      if (do_ins) begin
        if (SlotPos == pos_ext) begin
          cells_d[g] = val_q;
        end else if (SlotPos > pos_ext) begin
          cells_d[g] = cells_q[Prev];
        end
      end else if (do_rem) begin
        if (SlotPos >= pos_ext) begin
          cells_d[g] = cells_q[Next];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins || do_rem) begin
      cells_q <= cells_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      res_vld_q <= in_vld_q;
    end
  end

  // result payload, shown for one cycle with done_o
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_val_q <= rd_val;
      res_st_q  <= st;
      res_cnt_q <= cnt_d;
    end
  end

  assign done_o        = res_vld_q;
  assign value_out_o   = res_val_q;
  assign status_o      = res_st_q;
  assign entry_count_o = res_cnt_q;

endmodule

`default_nettype wire

FILE: sv/ple_checker.sv
// port-level checks of the positional list engine, bound to the top level
// depends on ple_pkg and positional_list_engine_defines.svh
`default_nettype none
`include "positional_list_engine_defines.svh"

module ple_checker #(
  parameter int unsigned DEPTH = ple_pkg::DepthDefault,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_i,
  input wire logic signed [31:0] value_out_i,
  input wire logic [1:0]         status_i,
  input wire logic [CntW-1:0]    entry_count_i
);
  import ple_pkg::*;

  // every accepted command gets its result through the input and result registers
  `PLE_ASSERT_IMP(a_result_follows, clk_i, rst_ni, start && !busy, ##2 done_i)

  // the count never exceeds the row depth
  `PLE_ASSERT_IMP(a_count_bound, clk_i, rst_ni, done_i, entry_count_i <= CntW'(DEPTH))

  // a failed command returns zero data
  `PLE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, done_i && (status_i != ST_OK),
                  value_out_i == 32'sd0)

  // a failed command leaves the count as the previous result reported it
  `PLE_ASSERT_IMP(a_err_keeps_count, clk_i, rst_ni,
                  done_i && $past(done_i) && (status_i != ST_OK),
                  entry_count_i == $past(entry_count_i))

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_i        (done_o),
  .value_out_i   (value_out_o),
  .status_i      (status_o),
  .entry_count_i (entry_count_o)
);

`default_nettype wire
